[rtl/edma_pkg.sv]
// Shared constants and register codes for the echo distance moving average block.
package edma_pkg;

  localparam int ENTRY_W   = 10;
  localparam int DIST_W    = 11;
  localparam int TICKS_W   = 16;
  localparam int SCALE_W   = 16;
  localparam int PROD_W    = TICKS_W + SCALE_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W    = 2;
  localparam int SLOT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  localparam logic [ENTRY_W-1:0] MIN_DIST_RST = 10'd2;
  localparam logic [ENTRY_W-1:0] MAX_DIST_RST = 10'd200;
  localparam logic [SCALE_W-1:0] SCALE_RST    = 16'd1114;

  localparam logic [DIST_W-1:0]  DIST_SAT     = 11'h7FF;

endpackage

[rtl/edma_ram.sv]
// Synchronous single-write, single-read memory with registered read data.
module edma_ram #(
  parameter int DEPTH = 20,
  parameter int WIDTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A read in the same cycle as a write to the same entry returns the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/edma_avg.sv]
// Window average: running sum divided by the window size through a reciprocal multiply.
module edma_avg #(
  parameter int WINDOW = 5,
  parameter int SUM_W  = 13
) (
  input  logic [SUM_W-1:0]            sum_i,
  input  logic                        valid_i,
  output logic [edma_pkg::ENTRY_W-1:0] avg_o
);
  import edma_pkg::*;

  // With K = SUM_W + ceil(log2(WINDOW)) the rounded-up reciprocal is exact for every sum.
  localparam int LW     = $clog2(WINDOW);
  localparam int K      = SUM_W + LW;
  localparam int PW     = SUM_W + K + 1;
  localparam logic [K:0] RECIP = (K + 1)'(((1 << K) + WINDOW - 1) / WINDOW);

  logic [PW-1:0] prod;

  assign prod  = PW'(sum_i) * PW'(RECIP);
  assign avg_o = valid_i ? prod[K +: ENTRY_W] : '0;

endmodule

[rtl/echo_distance_moving_average_core.sv]
// Top level: echo distance conversion, range check and per-channel windowed average.
// An accepted falling-edge beat is registered in stage 1, then in the output register where it is offered.
// Throughput: one beat per cycle while the output does not stall; the window and sum memories are read at
// acceptance and written back as stage 1 advances, with the last write forwarded to the following beat.
// Reset clears the fill masks and control state at once; no clearing pass is needed.
module echo_distance_moving_average_core #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [edma_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [edma_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [edma_pkg::CHAN_W-1:0]       channel_i,
  input  logic                              echo_level_i,
  input  logic [edma_pkg::SLOT_W-1:0]       slot_i,
  input  logic [edma_pkg::TICKS_W-1:0]      pulse_ticks_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [edma_pkg::CHAN_W-1:0]       result_channel_o,
  output logic [edma_pkg::DIST_W-1:0]       distance_cm_o,
  output logic                              in_range_o,
  output logic [edma_pkg::ENTRY_W-1:0]      average_cm_o,
  output logic                              average_valid_o
);
  import edma_pkg::*;

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLW   = $clog2(WINDOW);
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = $clog2(WINDOW * ((1 << ENTRY_W) - 1) + 1);

  // Configuration registers
  logic [ENTRY_W-1:0] min_dist_q, max_dist_q;
  logic [SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= MIN_DIST_RST;
      max_dist_q <= MAX_DIST_RST;
      scale_q    <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DIST: min_dist_q <= cfg_data_i[ENTRY_W-1:0];
        CFG_MAX_DIST: max_dist_q <= cfg_data_i[ENTRY_W-1:0];
        CFG_SCALE:    scale_q    <= cfg_data_i[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv, in_acc, s1_load, chan_ok, slot_ok;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign chan_ok    = 5'(channel_i) < 5'(CHANNELS);
  assign slot_ok    = 5'(slot_i) < 5'(WINDOW);
  // Rising edges and unknown channels are taken and dropped here.
  assign s1_load    = in_acc && !echo_level_i && chan_ok;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage 1 payload: product registered straight after the multiplier
  logic [CHAN_W-1:0] s1_chan_q;
  logic [SLW-1:0]    s1_slot_q;
  logic              s1_slot_ok_q;
  logic [AW-1:0]     s1_addr_q;
  logic [PROD_W-1:0] s1_prod_q;
  logic [CW-1:0]     in_ch_idx;
  logic [AW-1:0]     in_addr;

  assign in_ch_idx = CW'(channel_i);
  assign in_addr   = AW'(in_ch_idx) * AW'(WINDOW) + AW'(SLW'(slot_i));

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_chan_q    <= channel_i;
      s1_slot_q    <= SLW'(slot_i);
      s1_slot_ok_q <= slot_ok;
      s1_addr_q    <= in_addr;
      s1_prod_q    <= PROD_W'(pulse_ticks_i) * PROD_W'(scale_q);
    end
  end

  // Memories: window entries and per-channel running sums
  logic               wr_en;
  logic [ENTRY_W-1:0] entry_rdata, new_entry;
  logic [SUM_W-1:0]   sum_rdata, new_sum;
  logic [CW-1:0]      s1_ch_idx;

  assign s1_ch_idx = CW'(s1_chan_q);

  edma_ram #(.DEPTH(DEPTH), .WIDTH(ENTRY_W)) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_entry),
    .re_i    (s1_load),
    .raddr_i (in_addr),
    .rdata_o (entry_rdata)
  );

  edma_ram #(.DEPTH(CHANNELS), .WIDTH(SUM_W)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_ch_idx),
    .wdata_i (new_sum),
    .re_i    (s1_load),
    .raddr_i (in_ch_idx),
    .rdata_o (sum_rdata)
  );

  // Fill masks double as valid bits: an unfilled entry reads as zero, and so does the
  // sum of a channel with nothing filled.
  logic [WINDOW-1:0] fill_q [CHANNELS];

  // Last write, forwarded to a beat whose memory read raced it
  logic               wr_valid_q;
  logic [AW-1:0]      wr_addr_q;
  logic [CW-1:0]      wr_ch_q;
  logic [ENTRY_W-1:0] wr_entry_q;
  logic [SUM_W-1:0]   wr_sum_q;

  logic [DIST_W-1:0]  dist_cm;
  logic               in_rng;
  logic [WINDOW-1:0]  filled_cur, slot_oh, new_mask;
  logic [ENTRY_W-1:0] old_entry;
  logic [SUM_W-1:0]   old_sum;
  logic               upd;

  always_comb begin
    dist_cm    = (|s1_prod_q[PROD_W-1:16+DIST_W]) ? DIST_SAT : s1_prod_q[16 +: DIST_W];
    in_rng     = (dist_cm >= DIST_W'(min_dist_q)) && (dist_cm <= DIST_W'(max_dist_q));
    upd        = in_rng && s1_slot_ok_q;
    wr_en      = s1_adv && upd;
    new_entry  = dist_cm[ENTRY_W-1:0];
    filled_cur = fill_q[s1_ch_idx];
    slot_oh    = s1_slot_ok_q ? (WINDOW'(1) << s1_slot_q) : '0;
    new_mask   = filled_cur | (upd ? slot_oh : '0);
    old_entry  = '0;
    if (|(filled_cur & slot_oh)) begin
      old_entry = (wr_valid_q && wr_addr_q == s1_addr_q) ? wr_entry_q : entry_rdata;
    end
    old_sum = '0;
    if (|filled_cur) begin
      old_sum = (wr_valid_q && wr_ch_q == s1_ch_idx) ? wr_sum_q : sum_rdata;
    end
    new_sum = upd ? (old_sum - SUM_W'(old_entry) + SUM_W'(new_entry)) : old_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        fill_q[c] <= '0;
      end
    end else if (wr_en) begin
      wr_valid_q         <= 1'b1;
      fill_q[s1_ch_idx] <= new_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wr_addr_q  <= s1_addr_q;
      wr_ch_q    <= s1_ch_idx;
      wr_entry_q <= new_entry;
      wr_sum_q   <= new_sum;
    end
  end

  // Output register
  logic [CHAN_W-1:0] out_chan_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_rng_q, out_avg_valid_q;
  logic [SUM_W-1:0]  out_sum_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_chan_q      <= s1_chan_q;
      out_dist_q      <= dist_cm;
      out_rng_q       <= in_rng;
      out_sum_q       <= new_sum;
      out_avg_valid_q <= &new_mask;
    end
  end

  edma_avg #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_avg (
    .sum_i   (out_sum_q),
    .valid_i (out_avg_valid_q),
    .avg_o   (average_cm_o)
  );

  assign out_valid_o      = out_valid_q;
  assign result_channel_o = out_chan_q;
  assign distance_cm_o    = out_dist_q;
  assign in_range_o       = out_rng_q;
  assign average_valid_o  = out_avg_valid_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled without a blocked beat in stage 1");

  a_stage1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_addr_q))
    else $error("stage 1 beat lost while blocked");

  a_write_only_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s1_valid_q && s1_slot_ok_q && in_rng)
    else $error("memory written for a rejected beat");

  a_write_sets_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> wr_valid_q && $past(new_mask) == fill_q[$past(s1_ch_idx)])
    else $error("fill mask not updated after write");

  a_avg_zero_when_unfilled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !average_valid_o |-> average_cm_o == '0)
    else $error("average shown before the window is full");
`endif

endmodule

[verif/echo_result_checker.sv]
// Watches the echo edge and result channels, predicts each measurement beat and compares it.
module echo_result_checker #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [edma_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [edma_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [edma_pkg::CHAN_W-1:0]       channel_i,
  input  logic                              echo_level_i,
  input  logic [edma_pkg::SLOT_W-1:0]       slot_i,
  input  logic [edma_pkg::TICKS_W-1:0]      pulse_ticks_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [edma_pkg::CHAN_W-1:0]       result_channel_i,
  input  logic [edma_pkg::DIST_W-1:0]       distance_cm_i,
  input  logic                              in_range_i,
  input  logic [edma_pkg::ENTRY_W-1:0]      average_cm_i,
  input  logic                              average_valid_i,
  output int                                pending_o,
  output int                                failures_o,
  output int                                checked_o,
  output int                                full_o
);

  import edma_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [DIST_W-1:0]  distance;
    logic               in_range;
    logic [ENTRY_W-1:0] average;
    logic               average_valid;
  } echo_result_t;

  echo_result_t expected_q[$];

  logic [ENTRY_W-1:0] range_lo;
  logic [ENTRY_W-1:0] range_hi;
  logic [SCALE_W-1:0] scale;

  logic [ENTRY_W-1:0] window_mem [CHANNELS][WINDOW];
  logic [12:0]        window_sum [CHANNELS];
  logic [WINDOW-1:0]  filled     [CHANNELS];

  int failures;
  int checked;
  int full;

  assign failures_o = failures;
  assign checked_o  = checked;
  assign full_o     = full;

  // Converts the echo, folds it into the channel's window and queues the result.
  task automatic measure_echo(input logic [CHAN_W-1:0] ch, input logic [SLOT_W-1:0] sl,
                              input logic [TICKS_W-1:0] ticks);
    logic [PROD_W-1:0] product;
    logic [15:0]       whole_cm;
    echo_result_t      res;
    begin
      product  = {{SCALE_W{1'b0}}, ticks} * {{TICKS_W{1'b0}}, scale};
      whole_cm = product[PROD_W-1:16];
      res.channel  = ch;
      res.distance = (whole_cm > 16'(DIST_SAT)) ? DIST_SAT : whole_cm[DIST_W-1:0];
      res.in_range = (res.distance >= {1'b0, range_lo}) && (res.distance <= {1'b0, range_hi});
      if (res.in_range && sl < WINDOW) begin
        window_sum[ch] = window_sum[ch] - window_mem[ch][sl] + res.distance;
        window_mem[ch][sl] = res.distance[ENTRY_W-1:0];
        filled[ch][sl] = 1'b1;
      end
      res.average_valid = &filled[ch];
      res.average = res.average_valid ? ENTRY_W'(window_sum[ch] / WINDOW) : '0;
      expected_q.push_back(res);
    end
  endtask

  task automatic check_result();
    echo_result_t got;
    echo_result_t want;
    begin
      got = {result_channel_i, distance_cm_i, in_range_i, average_cm_i, average_valid_i};
      checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: ch %0d dist %0d range %0b avg %0d valid %0b",
                   got.channel, got.distance, got.in_range, got.average, got.average_valid);
      end else begin
        want = expected_q.pop_front();
        if (want.average_valid)
          full++;
        if (got.channel !== want.channel || got.distance !== want.distance ||
            got.in_range !== want.in_range || got.average !== want.average ||
            got.average_valid !== want.average_valid) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected ch %0d dist %0d range %0b avg %0d valid %0b, %s",
                     want.channel, want.distance, want.in_range, want.average,
                     want.average_valid,
                     $sformatf("got ch %0d dist %0d range %0b avg %0d valid %0b",
                               got.channel, got.distance, got.in_range, got.average,
                               got.average_valid));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_lo = MIN_DIST_RST;
      range_hi = MAX_DIST_RST;
      scale    = SCALE_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        window_sum[c] = '0;
        filled[c]     = '0;
        for (int s = 0; s < WINDOW; s++)
          window_mem[c][s] = '0;
      end
      expected_q.delete();
      failures  = 0;
      checked   = 0;
      full      = 0;
      pending_o <= 0;
    end else begin
      // Results are taken before new predictions so that a stray beat never meets its own item.
      if (out_valid_i && !out_stall_i)
        check_result();
      if (in_valid_i && !in_stall_i && !echo_level_i && channel_i < CHANNELS)
        measure_echo(channel_i, slot_i, pulse_ticks_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_DIST: range_lo = cfg_data_i[ENTRY_W-1:0];
          CFG_MAX_DIST: range_hi = cfg_data_i[ENTRY_W-1:0];
          CFG_SCALE:    scale    = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

[verif/testbench.sv]
// Top of the regression: clock, reset, echo edge stimulus, result back-pressure and verdict.
module testbench;

  import edma_pkg::*;

  localparam int PHASES       = 8;
  localparam int PER_PHASE    = 80;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 1000000;

  // Index with no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [CHAN_W-1:0]    channel_i     = '0;
  logic                 echo_level_i  = 1'b0;
  logic [SLOT_W-1:0]    slot_i        = '0;
  logic [TICKS_W-1:0]   pulse_ticks_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [CHAN_W-1:0]    result_channel_o;
  logic [DIST_W-1:0]    distance_cm_o;
  logic                 in_range_o;
  logic [ENTRY_W-1:0]   average_cm_o;
  logic                 average_valid_o;

  int pending;
  int failures;
  int checked;
  int full;

  int cycles       = 0;
  int edges_sent   = 0;
  int measurements = 0;
  bit quiet        = 1'b0;
  bit hold_req     = 1'b0;

  logic [ENTRY_W-1:0] cur_min   = MIN_DIST_RST;
  logic [ENTRY_W-1:0] cur_max   = MAX_DIST_RST;
  logic [SCALE_W-1:0] cur_scale = SCALE_RST;

  echo_distance_moving_average_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .channel_i, .echo_level_i, .slot_i, .pulse_ticks_i,
    .out_valid_o, .out_stall_i, .result_channel_o, .distance_cm_o, .in_range_o,
    .average_cm_o, .average_valid_o
  );

  echo_result_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .channel_i, .echo_level_i, .slot_i,
    .pulse_ticks_i, .out_valid_i(out_valid_o), .out_stall_i,
    .result_channel_i(result_channel_o), .distance_cm_i(distance_cm_o),
    .in_range_i(in_range_o), .average_cm_i(average_cm_o),
    .average_valid_i(average_valid_o),
    .pending_o(pending), .failures_o(failures), .checked_o(checked), .full_o(full)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("echo_distance_moving_average_core regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (r < 55)
        return 0;
      if (r < 88)
        return $urandom_range(1, 3);
      if (r < 97)
        return $urandom_range(4, 12);
      return $urandom_range(20, 60);
    end
  endfunction

  // Result side back-pressure; a requested hold-off is counted out here.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 2) == 0)
          stall_left = idle_len();
      end
    end
  end

  // Timer count that lands inside the current range, so that windows actually fill.
  function automatic logic [TICKS_W-1:0] aimed_ticks();
    longint d;
    longint t;
    begin
      if (cur_min > cur_max)
        return TICKS_W'($urandom_range(0, 65535));
      d = $urandom_range(cur_min, cur_max);
      t = (d * 65536 + longint'(cur_scale) - 1) / longint'(cur_scale);
      if (t > 65535)
        t = 65535;
      return t[TICKS_W-1:0];
    end
  endfunction

  task automatic send_edge(input logic [CHAN_W-1:0] ch, input logic lvl,
                           input logic [SLOT_W-1:0] sl, input logic [TICKS_W-1:0] ticks);
    int gap;
    begin
      gap = quiet ? 0 : idle_len();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      channel_i     <= ch;
      echo_level_i  <= lvl;
      slot_i        <= sl;
      pulse_ticks_i <= ticks;
      @(posedge clk_i);
      while (in_stall_o)
        @(posedge clk_i);
      edges_sent++;
      if (!lvl)
        measurements++;
    end
  endtask

  // Waits until every expected result has come and the block has gone quiet.
  task automatic drain();
    begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (pending != 0)
        @(posedge clk_i);
      repeat (SETTLE) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data;
      @(posedge clk_i);
    end
  endtask

  task automatic set_config(input logic [ENTRY_W-1:0] lo, input logic [ENTRY_W-1:0] hi,
                            input logic [SCALE_W-1:0] scale);
    logic [CFG_W-ENTRY_W-1:0] junk;
    logic [CFG_W-1:0]         spare_data;
    begin
      // Bits above a register's width carry noise; the block must drop them.
      junk = (CFG_W-ENTRY_W)'($urandom_range(0, 63));
      write_reg(CFG_MIN_DIST, {junk, lo});
      junk = (CFG_W-ENTRY_W)'($urandom_range(0, 63));
      write_reg(CFG_MAX_DIST, {junk, hi});
      write_reg(CFG_SCALE, scale);
      spare_data = CFG_W'($urandom_range(0, 65535));
      write_reg(CFG_SPARE, spare_data);
      cfg_we_i  <= 1'b0;
      cur_min   = lo;
      cur_max   = hi;
      cur_scale = scale;
    end
  endtask

  initial begin
    int                 falls;
    logic [CHAN_W-1:0]  ch;
    logic               lvl;
    logic [ENTRY_W-1:0] lo;
    logic [ENTRY_W-1:0] hi;
    logic [SCALE_W-1:0] scale;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: begin lo = 10'd0;    hi = 10'd1023; scale = 16'hFFFF; end
          2: begin lo = 10'd1023; hi = 10'd0;    scale = 16'd1;    end
          3: begin lo = 10'd0;    hi = 10'd0;    scale = 16'd1;    end
          4: begin lo = 10'd1023; hi = 10'd1023; scale = 16'hFFFF; end
          7: begin
            lo = ENTRY_W'($urandom_range(0, 1023));
            hi = ENTRY_W'($urandom_range(0, 1023));
            scale = SCALE_W'($urandom_range(1, 65535));
          end
          default: begin
            lo = ENTRY_W'($urandom_range(0, 300));
            hi = ENTRY_W'($urandom_range(lo, 1023));
            scale = SCALE_W'($urandom_range(500, 3000));
          end
        endcase
        set_config(lo, hi, scale);
      end
      quiet = (p == 3 || p == 6);
      if (p == 1 || p == 5)
        hold_req = 1'b1;

      if (p == 0) begin
        // Default range 2..200 cm: both bounds, just outside them, and slots past the window.
        send_edge(2'd3, 1'b1, 3'd7, 16'hFFFF);
        send_edge(2'd0, 1'b0, 3'd0, 16'h0000);
        send_edge(2'd0, 1'b0, 3'd7, 16'hFFFF);
        send_edge(2'd1, 1'b0, 3'd0, 16'd117);
        send_edge(2'd1, 1'b0, 3'd0, 16'd118);
        send_edge(2'd1, 1'b0, 3'd1, 16'd11766);
        send_edge(2'd1, 1'b0, 3'd2, 16'd11825);
        send_edge(2'd1, 1'b0, 3'd2, 16'd5883);
        send_edge(2'd1, 1'b0, 3'd3, 16'd2942);
        send_edge(2'd1, 1'b0, 3'd5, 16'd5883);
        send_edge(2'd1, 1'b0, 3'd4, 16'd9000);
        send_edge(2'd1, 1'b0, 3'd2, 16'd1000);
        send_edge(2'd1, 1'b1, 3'd0, 16'h0000);
        send_edge(2'd2, 1'b0, 3'd6, 16'd3000);
        send_edge(2'd0, 1'b1, 3'd0, 16'hFFFF);
      end else if (p == 1) begin
        // Full scale: products past 2047 cm must saturate.
        send_edge(2'd2, 1'b0, 3'd0, 16'hFFFF);
        send_edge(2'd2, 1'b0, 3'd1, 16'd2048);
        send_edge(2'd2, 1'b0, 3'd2, 16'd2049);
        send_edge(2'd3, 1'b0, 3'd4, 16'd1);
      end

      falls = 0;
      while (falls < PER_PHASE) begin
        if ($urandom_range(0, 99) < 80) begin
          ch = CHAN_W'($urandom_range(0, 3));
          send_edge(ch, 1'b1, SLOT_W'($urandom_range(0, 7)),
                    TICKS_W'($urandom_range(0, 65535)));
          send_edge(ch, 1'b0, SLOT_W'($urandom_range(0, 4)), aimed_ticks());
          falls++;
        end else begin
          lvl = 1'($urandom_range(0, 1));
          send_edge(CHAN_W'($urandom_range(0, 3)), lvl, SLOT_W'($urandom_range(0, 7)),
                    TICKS_W'($urandom_range(0, 65535)));
          if (!lvl)
            falls++;
        end
      end
    end

    drain();
    $display("sent %0d echo edges, %0d of them falling, across %0d range and scale settings",
             edges_sent, measurements, PHASES);
    $display("checked %0d result beats, %0d of them with a full window; %0d failures",
             checked, full, failures);
    if (failures == 0)
      $display("echo_distance_moving_average_core regression: pass");
    else
      $display("echo_distance_moving_average_core regression: fail");
    $finish;
  end

endmodule
